// File: rtl/core/tshb_pkg.sv
// Shared types, constants and register codes of the sample history buffer.
package tshb_pkg;

    localparam int VALUE_W      = 64;
    localparam int TIME_W       = 48;
    localparam int MONO_W       = 48;
    localparam int INTERVAL_W   = 32;
    localparam int BSIZE_W      = 6;
    localparam int SLOT_FIELD_W = 3;
    localparam int MAXC_W       = 6;
    localparam int CONS_FIELD_W = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = INTERVAL_W;

    // Width used for size and count comparisons; covers every legal depth.
    localparam int CMP_W = BSIZE_W + 1;

    localparam int NUM_SLOTS_DEF     = 8;
    localparam int DEPTH_DEF         = 32;
    localparam int NUM_CONSUMERS_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEND_ONCE    = 2'd2;

    localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST = '0;
    localparam logic [BSIZE_W-1:0]    BUFFER_SIZE_RST  = 6'd32;
    localparam logic                  SEND_ONCE_RST    = 1'b1;

    localparam logic CMD_ADD     = 1'b0;
    localparam logic CMD_COLLECT = 1'b1;

    typedef struct packed {
        logic               accepted;
        logic               has_sample;
        logic [VALUE_W-1:0] sample_value;
        logic [TIME_W-1:0]  sample_time;
        logic [TIME_W-1:0]  newest_time;
        logic               last;
    } t_result;

endpackage

// File: rtl/core/tshb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module tshb_ram #(
    parameter  int WIDTH  = 8,
    parameter  int WORDS  = 16,
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [WORDS];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/tshb_keep_check.sv
// Throttle decision and ring position and count update for an add.
module tshb_keep_check #(
    parameter  int DEPTH = tshb_pkg::DEPTH_DEF,
    localparam int POS_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                            i_slot_ok,
    input  logic                            i_seen,
    input  logic [CNT_W-1:0]                i_sz,
    input  logic [POS_W-1:0]                i_pos,
    input  logic [CNT_W-1:0]                i_cnt,
    input  logic [tshb_pkg::MONO_W-1:0]     i_last_mono,
    input  logic [tshb_pkg::MONO_W-1:0]     i_mono,
    input  logic [tshb_pkg::INTERVAL_W-1:0] i_interval,
    output logic                            o_keep,
    output logic [POS_W-1:0]                o_next_pos,
    output logic [CNT_W-1:0]                o_next_cnt
);
    import tshb_pkg::*;

    logic [MONO_W:0]  threshold;
    logic [CNT_W:0]   pos_inc;
    logic [CNT_W:0]   cnt_inc;
    logic [CNT_W:0]   sz_ext;

    // The threshold carries one extra bit so that the sum never wraps.
    assign threshold = {1'b0, i_last_mono} + (MONO_W + 1)'(i_interval);

    assign o_keep = i_slot_ok && (i_sz != '0) &&
                    ((i_interval == '0) || !i_seen || ({1'b0, i_mono} >= threshold));

    assign sz_ext  = (CNT_W + 1)'(i_sz);
    assign pos_inc = (CNT_W + 1)'(i_pos) + (CNT_W + 1)'(1);
    assign cnt_inc = (CNT_W + 1)'(i_cnt) + (CNT_W + 1)'(1);

    assign o_next_pos = (pos_inc >= sz_ext) ? '0 : POS_W'(pos_inc);
    assign o_next_cnt = (cnt_inc > sz_ext) ? i_sz : CNT_W'(cnt_inc);

endmodule

// File: rtl/core/tshb_out_stage.sv
// Output register that holds one result until the receiver takes it.
module tshb_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tshb_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_valid,
    output logic              o_free,
    output tshb_pkg::t_result o_result
);
    import tshb_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: rtl/core/throttled_sample_history_buffer_top.sv
// Top level of the throttled sample history buffer: sequencer, memories and ports.
// Items arrive on the input channel (i_in_valid / o_in_stall); a transfer happens at
// a clock edge with valid high and stall low. An add item (cmd 0) stores a sample in
// the addressed slot's ring unless the slot is invalid or throttled or the size is zero;
// it yields one result, with accepted telling if it was stored and last set. A collect
// item (cmd 1) walks back from the newest entry of the slot and yields one result per
// emitted sample, newest first, with last set on the final one; when nothing is
// emitted it yields a single result with has_sample clear. Results leave through an
// output register on o_out_valid / i_out_stall. Items are handled one at a time: while
// the receiver stalls, the result holds and the block finishes its current item up to
// the point where it needs the output register again; the next input item is taken in
// the cycle after the last result of the current one enters that register. An add
// decides in S_SLOT and loads its result there when the output register is free, else
// from S_FINAL. A collect reads each walked entry in S_WALK_RD and writes back the marks
// of each emitted one in S_WALK_WB, then runs an emit pass that reads each emitted sample
// again, or gives the single empty result from S_FINAL when nothing is emitted.
// Configuration (i_cfg_valid / o_cfg_ready) is always ready. Reset clears slot history
// (write position, count, last kept time, first-sample flag) at once through per-slot
// flags; sample entries need no clearing because a walk only reaches entries that were
// written.
module throttled_sample_history_buffer_top #(
    parameter int NUM_SLOTS     = tshb_pkg::NUM_SLOTS_DEF,
    parameter int DEPTH         = tshb_pkg::DEPTH_DEF,
    parameter int NUM_CONSUMERS = tshb_pkg::NUM_CONSUMERS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel.
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_cmd,
    input  logic [tshb_pkg::SLOT_FIELD_W-1:0] i_buffer_slot,
    input  logic [tshb_pkg::MONO_W-1:0]       i_recv_mono_ms,
    input  logic [tshb_pkg::TIME_W-1:0]       i_recv_sys_ms,
    input  logic [tshb_pkg::VALUE_W-1:0]      i_value_in,
    input  logic [tshb_pkg::MAXC_W-1:0]       i_max_count,
    input  logic [tshb_pkg::CONS_FIELD_W-1:0] i_consumer_id,
    // Output channel.
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_accepted,
    output logic                              o_has_sample,
    output logic [tshb_pkg::VALUE_W-1:0]      o_sample_value,
    output logic [tshb_pkg::TIME_W-1:0]       o_sample_time,
    output logic [tshb_pkg::TIME_W-1:0]       o_newest_time,
    output logic                              o_last,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tshb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tshb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tshb_pkg::*;

    localparam int POS_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ENTRY_WORDS = NUM_SLOTS * DEPTH;
    localparam int ADDR_W      = $clog2(ENTRY_WORDS);
    localparam int ENTRY_W     = VALUE_W + TIME_W + NUM_CONSUMERS;
    localparam int SLOT_WORD_W = MONO_W + CNT_W + POS_W;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_SLOT    = 7'b0000010,
        S_WALK_RD = 7'b0000100,
        S_WALK_WB = 7'b0001000,
        S_EM_SCAN = 7'b0010000,
        S_EM_OUT  = 7'b0100000,
        S_FINAL   = 7'b1000000
    } t_state;

    function automatic logic [ADDR_W-1:0] entry_addr(input logic [SLOT_W-1:0] s,
                                                     input logic [POS_W-1:0]  p);
        return ADDR_W'(s) * ADDR_W'(DEPTH) + ADDR_W'(p);
    endfunction

    // Configuration registers.
    logic [INTERVAL_W-1:0]   r_min_interval;
    logic [BSIZE_W-1:0]      r_buffer_size;
    logic                    r_send_once;

    // Sequencer state.
    t_state                  r_state, n_state;
    logic [NUM_SLOTS-1:0]    r_seen, n_seen;
    logic [POS_W-1:0]        r_pos, n_pos;
    logic [POS_W-1:0]        r_start, n_start;
    logic [CNT_W-1:0]        r_left, n_left;
    logic [CNT_W-1:0]        r_emit_left, n_emit_left;
    logic [TIME_W-1:0]       r_newest, n_newest;
    logic                    r_keep, n_keep;
    logic [DEPTH-1:0]        r_mask, n_mask;

    // Captured input item.
    logic                    r_cmd;
    logic [SLOT_FIELD_W-1:0] r_slot;
    logic [MONO_W-1:0]       r_mono;
    logic [TIME_W-1:0]       r_sys;
    logic [VALUE_W-1:0]      r_value;
    logic [MAXC_W-1:0]       r_maxc;
    logic [CONS_FIELD_W-1:0] r_cons;

    logic                    in_xfer;
    logic [CNT_W-1:0]        sz;
    logic [SLOT_W-1:0]       slot_idx;
    logic                    slot_ok;
    logic                    seen;

    logic                    slot_wr_en;
    logic [SLOT_WORD_W-1:0]  slot_wr_data;
    logic [SLOT_WORD_W-1:0]  slot_rd_data;
    logic [POS_W-1:0]        slot_pos;
    logic [CNT_W-1:0]        slot_cnt;
    logic [MONO_W-1:0]       slot_mono;

    logic                    entry_wr_en;
    logic [ADDR_W-1:0]       entry_wr_addr;
    logic [ENTRY_W-1:0]      entry_wr_data;
    logic                    entry_rd_en;
    logic [ENTRY_W-1:0]      entry_rd_data;
    logic [NUM_CONSUMERS-1:0] w_marks;
    logic [TIME_W-1:0]       w_time;
    logic [VALUE_W-1:0]      w_value;
    logic                    w_emit;
    logic [NUM_CONSUMERS-1:0] mark_bit;

    logic                    keep;
    logic [POS_W-1:0]        next_pos;
    logic [CNT_W-1:0]        next_cnt;

    logic [CMP_W-1:0]        min_a;
    logic [CNT_W-1:0]        walk_n;
    logic [POS_W-1:0]        start_pos;
    logic [POS_W-1:0]        pos_dec;

    logic                    out_load;
    logic                    out_free;
    t_result                 out_data;
    t_result                 out_q;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Effective ring size: the size register, capped at the physical depth.
    assign sz = ({1'b0, r_buffer_size} > CMP_W'(DEPTH)) ? CNT_W'(DEPTH)
                                                         : CNT_W'(r_buffer_size);

    assign slot_idx = SLOT_W'(r_slot);
    assign slot_ok  = (32'(r_slot) < NUM_SLOTS);
    assign seen     = slot_ok && r_seen[slot_idx];

    // A slot that never kept a sample reads as all zero.
    assign slot_pos  = seen ? slot_rd_data[POS_W-1:0] : '0;
    assign slot_cnt  = seen ? slot_rd_data[POS_W +: CNT_W] : '0;
    assign slot_mono = seen ? slot_rd_data[POS_W + CNT_W +: MONO_W] : '0;

    assign slot_wr_data = {r_mono, next_cnt, next_pos};

    // Walk length: the smallest of the requested count, the stored count and the size.
    assign min_a  = (CMP_W'(r_maxc) < CMP_W'(slot_cnt)) ? CMP_W'(r_maxc) : CMP_W'(slot_cnt);
    assign walk_n = (!slot_ok || (sz == '0)) ? '0 :
                    (min_a < CMP_W'(sz)) ? CNT_W'(min_a) : sz;

    // A position left beyond a shrunk size restarts at entry zero.
    assign start_pos = (CMP_W'(slot_pos) >= CMP_W'(sz)) ? '0 : slot_pos;
    assign pos_dec   = (r_pos == '0) ? POS_W'(sz - CNT_W'(1)) : r_pos - POS_W'(1);

    assign w_marks = entry_rd_data[NUM_CONSUMERS-1:0];
    assign w_time  = entry_rd_data[NUM_CONSUMERS +: TIME_W];
    assign w_value = entry_rd_data[NUM_CONSUMERS + TIME_W +: VALUE_W];

    // A consumer outside the range tests as not consumed and sets no mark.
    assign mark_bit = (32'(r_cons) < NUM_CONSUMERS) ? (NUM_CONSUMERS'(1) << r_cons) : '0;
    assign w_emit   = ((w_marks & mark_bit) == '0) || !r_send_once;

    tshb_keep_check #(
        .DEPTH (DEPTH)
    ) u_keep_check (
        .i_slot_ok   (slot_ok),
        .i_seen      (seen),
        .i_sz        (sz),
        .i_pos       (slot_pos),
        .i_cnt       (slot_cnt),
        .i_last_mono (slot_mono),
        .i_mono      (r_mono),
        .i_interval  (r_min_interval),
        .o_keep      (keep),
        .o_next_pos  (next_pos),
        .o_next_cnt  (next_cnt)
    );

    tshb_ram #(
        .WIDTH (SLOT_WORD_W),
        .WORDS (NUM_SLOTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (slot_wr_en),
        .i_wr_addr (slot_idx),
        .i_wr_data (slot_wr_data),
        .i_rd_en   (in_xfer),
        .i_rd_addr (SLOT_W'(i_buffer_slot)),
        .o_rd_data (slot_rd_data)
    );

    tshb_ram #(
        .WIDTH (ENTRY_W),
        .WORDS (ENTRY_WORDS)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (entry_wr_en),
        .i_wr_addr (entry_wr_addr),
        .i_wr_data (entry_wr_data),
        .i_rd_en   (entry_rd_en),
        .i_rd_addr (entry_addr(slot_idx, r_pos)),
        .o_rd_data (entry_rd_data)
    );

    tshb_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (out_load),
        .i_result (out_data),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_free   (out_free),
        .o_result (out_q)
    );

    assign o_accepted     = out_q.accepted;
    assign o_has_sample   = out_q.has_sample;
    assign o_sample_value = out_q.sample_value;
    assign o_sample_time  = out_q.sample_time;
    assign o_newest_time  = out_q.newest_time;
    assign o_last         = out_q.last;

    // The sequencer. A collect makes two passes over the ring: the first reads each
    // walked entry, writes back the consumed marks of each emitted one and records which
    // entries are emitted; the second reads the emitted entries again, once the newest
    // timestamp of the whole walk is known, and sends them out.
    always_comb begin
        n_state       = r_state;
        n_seen        = r_seen;
        n_pos         = r_pos;
        n_start       = r_start;
        n_left        = r_left;
        n_emit_left   = r_emit_left;
        n_newest      = r_newest;
        n_keep        = r_keep;
        n_mask        = r_mask;
        slot_wr_en    = 1'b0;
        entry_wr_en   = 1'b0;
        entry_wr_addr = entry_addr(slot_idx, r_pos);
        entry_wr_data = {w_value, w_time, w_marks | mark_bit};
        entry_rd_en   = 1'b0;
        out_load      = 1'b0;
        out_data      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_SLOT;
                end
            end
            S_SLOT: begin
                n_newest = '0;
                n_keep   = 1'b0;
                if (r_cmd == CMD_ADD) begin
                    if (keep) begin
                        slot_wr_en        = 1'b1;
                        entry_wr_en       = 1'b1;
                        entry_wr_addr     = entry_addr(slot_idx, next_pos);
                        entry_wr_data     = {r_value, r_sys, {NUM_CONSUMERS{1'b0}}};
                        n_seen[slot_idx]  = 1'b1;
                    end
                    out_data.accepted = keep;
                    out_data.last     = 1'b1;
                    if (out_free) begin
                        out_load = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_keep  = keep;
                        n_state = S_FINAL;
                    end
                end else begin
                    n_pos       = start_pos;
                    n_start     = start_pos;
                    n_left      = walk_n;
                    n_emit_left = '0;
                    n_mask      = '0;
                    n_state     = (walk_n == '0) ? S_FINAL : S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                entry_rd_en = 1'b1;
                n_state     = S_WALK_WB;
            end
            S_WALK_WB: begin
                if (w_emit) begin
                    entry_wr_en   = 1'b1;
                    n_mask[r_pos] = 1'b1;
                end
                n_emit_left = r_emit_left + CNT_W'(w_emit);
                if (w_time > r_newest) begin
                    n_newest = w_time;
                end
                n_left = r_left - CNT_W'(1);
                if (r_left == CNT_W'(1)) begin
                    n_pos   = r_start;
                    n_state = (n_emit_left == '0) ? S_FINAL : S_EM_SCAN;
                end else begin
                    n_pos   = pos_dec;
                    n_state = S_WALK_RD;
                end
            end
            S_EM_SCAN: begin
                if (r_mask[r_pos]) begin
                    entry_rd_en = 1'b1;
                    n_state     = S_EM_OUT;
                end
                n_pos = pos_dec;
            end
            S_EM_OUT: begin
                out_data.has_sample   = 1'b1;
                out_data.sample_value = w_value;
                out_data.sample_time  = w_time;
                out_data.newest_time  = r_newest;
                out_data.last         = (r_emit_left == CNT_W'(1));
                if (out_free) begin
                    out_load    = 1'b1;
                    n_emit_left = r_emit_left - CNT_W'(1);
                    n_state     = (r_emit_left == CNT_W'(1)) ? S_IDLE : S_EM_SCAN;
                end
            end
            S_FINAL: begin
                out_data.accepted    = r_keep;
                out_data.newest_time = r_newest;
                out_data.last        = 1'b1;
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_seen         <= '0;
            r_emit_left    <= '0;
            r_min_interval <= MIN_INTERVAL_RST;
            r_buffer_size  <= BUFFER_SIZE_RST;
            r_send_once    <= SEND_ONCE_RST;
        end else begin
            r_state     <= n_state;
            r_seen      <= n_seen;
            r_emit_left <= n_emit_left;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_MIN_INTERVAL: r_min_interval <= i_cfg_data;
                    REG_BUFFER_SIZE:  r_buffer_size  <= i_cfg_data[BSIZE_W-1:0];
                    REG_SEND_ONCE:    r_send_once    <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_start  <= n_start;
        r_left   <= n_left;
        r_newest <= n_newest;
        r_keep   <= n_keep;
        r_mask   <= n_mask;
        if (in_xfer) begin
            r_cmd   <= i_cmd;
            r_slot  <= i_buffer_slot;
            r_mono  <= i_recv_mono_ms;
            r_sys   <= i_recv_sys_ms;
            r_value <= i_value_in;
            r_maxc  <= i_max_count;
            r_cons  <= i_consumer_id;
        end
    end

`ifndef SYNTHESIS
    // An add result never carries a sample.
    a_add_no_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_accepted && o_has_sample))
        else $error("result marks both an accepted add and a collected sample");

    // A result without a sample is always the only, and so the final, one.
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_sample) |-> o_last)
        else $error("result without a sample is not marked last");

    // The emit pass only runs while emitted entries remain to be sent.
    a_emit_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EM_SCAN) |-> ((r_emit_left != '0) && (r_mask != '0)))
        else $error("emit pass running with nothing left to send");

    // Walk and emit positions stay inside the ring in use.
    a_pos_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WALK_RD) || (r_state == S_EM_SCAN)) |->
            (CMP_W'(r_pos) < CMP_W'(sz)))
        else $error("ring position beyond the buffer size");
`endif

endmodule
